### hw/rtl/a2pwm_pkg.sv
package a2pwm_pkg;

	// field widths
	localparam int ADC_W    = 10;
	localparam int CAL_W    = 11;
	localparam int TOP_W    = 16;
	localparam int PCT_W    = 7;
	localparam int MS_W     = 16;
	localparam int CMP_W    = 16;
	localparam int EVT_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// press timing
	localparam int TICK_MS   = 5;
	localparam int PRESS_CAP = 60000;

	// calibration fallback and reset values
	localparam logic [CAL_W-1:0] ADC_FULL = CAL_W'(1023);
	localparam logic [TOP_W-1:0] RST_PERIOD_TOP = TOP_W'(99);
	localparam logic [PCT_W-1:0] RST_DUTY_MIN = PCT_W'(15);
	localparam logic [PCT_W-1:0] RST_DUTY_MAX = PCT_W'(90);
	localparam logic [MS_W-1:0]  RST_DEBOUNCE = MS_W'(20);
	localparam logic [MS_W-1:0]  RST_LONG_PRESS = MS_W'(1000);
	localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

	// serial divider sizes
	localparam int DIV_NUM_W = 27;
	localparam int DIV_DEN_W = 12;
	localparam int DIV_CNT_W = 5;
	localparam int DIV_LAST  = DIV_NUM_W - 1;

	// period plus one and the clamp bounds
	localparam int PER_W = TOP_W + 1;
	localparam int BND_W = TOP_W + 2;

	// percentage bounds: divide by one hundred through a reciprocal multiply,
	// exact for every numerator below 2^23
	localparam int PCT_NUM_W   = 23;
	localparam int PCT_RECIP_W = 24;
	localparam int PCT_PROD_W  = PCT_NUM_W + PCT_RECIP_W;
	localparam int PCT_SHIFT   = 30;
	localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = PCT_RECIP_W'(10737419);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TOP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_MIN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_MAX    = 3'd6;

	// save event codes
	localparam logic [EVT_W-1:0] EVT_NONE = 2'd0;
	localparam logic [EVT_W-1:0] EVT_MIN  = 2'd1;
	localparam logic [EVT_W-1:0] EVT_MAX  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic mul;
		logic div_start;
		logic fix;
		logic out_load;
	} a2pwm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_done;
		logic out_free;
	} a2pwm_sts_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIVS = 6'b000100,
		ST_DIVW = 6'b001000,
		ST_FIX  = 6'b010000,
		ST_DONE = 6'b100000
	} a2pwm_state_t;

endpackage

### hw/rtl/a2pwm_div.sv
module a2pwm_div
	import a2pwm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] quo,
	output logic                 done
);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	// one restoring step per cycle
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_LAST)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// quotient and remainder shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

### hw/rtl/a2pwm_ctrl.sv
module a2pwm_ctrl
	import a2pwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  a2pwm_sts_t sts,
	output a2pwm_cmd_t cmd
);

	a2pwm_state_t state_q;
	a2pwm_state_t state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (sts.div_done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/a2pwm_dp.sv
module a2pwm_dp
	import a2pwm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [ADC_W-1:0]      adc_average,
	input  logic                  button_down,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CMP_W-1:0]      compare_value,
	output logic [EVT_W-1:0]      save_event,
	output logic [CAL_W-1:0]      cal_min_out,
	output logic [CAL_W-1:0]      cal_max_out,
	input  a2pwm_cmd_t            cmd,
	output a2pwm_sts_t            sts
);

	// configuration registers
	logic [TOP_W-1:0] period_top_q;
	logic [PCT_W-1:0] duty_min_q;
	logic [PCT_W-1:0] duty_max_q;
	logic [MS_W-1:0]  debounce_q;
	logic [MS_W-1:0]  long_press_q;
	logic [CAL_W-1:0] init_min_q;
	logic [CAL_W-1:0] init_max_q;

	// calibration and press state
	logic [CAL_W-1:0] cal_min_q;
	logic [CAL_W-1:0] cal_max_q;
	logic [MS_W-1:0]  press_q;
	logic             was_down_q;

	// pipeline of one request
	logic [CAL_W-1:0]     adj_s1;
	logic [DIV_DEN_W-1:0] span1_s1;
	logic [PCT_W-1:0]     pmin_s1;
	logic [PCT_W-1:0]     pmax_s1;
	logic [EVT_W-1:0]     evt_s1;
	logic [CAL_W-1:0]     cmin_s1;
	logic [CAL_W-1:0]     cmax_s1;
	logic [DIV_NUM_W-1:0] prod_s2;
	logic [PCT_NUM_W-1:0] plo_s2;
	logic [PCT_NUM_W-1:0] phi_s2;
	logic [BND_W-1:0]     lo_div_s2;
	logic [BND_W-1:0]     hi_div_s2;
	logic [BND_W-1:0]     ccr_s3;
	logic [BND_W-1:0]     lo_s3;
	logic [BND_W-1:0]     hi_s3;

	logic             out_valid_q;
	logic [CMP_W-1:0] cmp_q;
	logic [EVT_W-1:0] evt_q;
	logic [CAL_W-1:0] cmin_q;
	logic [CAL_W-1:0] cmax_q;

	logic [DIV_NUM_W-1:0] q_ccr;
	logic                 d_ccr;

	// calibration reload with fallback
	logic [CAL_W-1:0] ld_min;
	logic [CAL_W-1:0] ld_max;
	logic [CAL_W-1:0] wr_min;
	logic [CAL_W-1:0] wr_max;

	always_comb begin
		wr_min = init_min_q;
		wr_max = init_max_q;
		if (cfg_index == REG_INIT_MIN) begin
			wr_min = cfg_data[CAL_W-1:0];
		end
		if (cfg_index == REG_INIT_MAX) begin
			wr_max = cfg_data[CAL_W-1:0];
		end
		if (wr_max <= wr_min) begin
			ld_min = '0;
			ld_max = ADC_FULL;
		end else begin
			ld_min = wr_min;
			ld_max = wr_max;
		end
	end

	// clamp of the reading to the current window
	logic [CAL_W-1:0] raw;
	logic [CAL_W-1:0] adc_c;
	logic [PCT_W-1:0] pmin_c;
	logic [PCT_W-1:0] pmax_c;

	always_comb begin
		raw   = {1'b0, adc_average};
		adc_c = raw;
		if (adc_c < cal_min_q) begin
			adc_c = cal_min_q;
		end
		if (adc_c > cal_max_q) begin
			adc_c = cal_max_q;
		end
		pmin_c = (duty_min_q > PCT_FULL) ? PCT_FULL : duty_min_q;
		pmax_c = (duty_max_q > PCT_FULL) ? PCT_FULL : duty_max_q;
	end

	// press timing and calibration update
	logic [MS_W:0]    press_inc;
	logic [MS_W-1:0]  press_d;
	logic [CAL_W-1:0] cal_min_d;
	logic [CAL_W-1:0] cal_max_d;
	logic [EVT_W-1:0] evt_d;

	always_comb begin
		press_inc = {1'b0, press_q} + (MS_W+1)'(TICK_MS);
		press_d   = press_q;
		cal_min_d = cal_min_q;
		cal_max_d = cal_max_q;
		evt_d     = EVT_NONE;
		if (button_down) begin
			if (press_q < MS_W'(PRESS_CAP)) begin
				if (press_inc > (MS_W+1)'(PRESS_CAP)) begin
					press_d = MS_W'(PRESS_CAP);
				end else begin
					press_d = press_inc[MS_W-1:0];
				end
			end
		end else if (was_down_q) begin
			if (press_q >= long_press_q) begin
				cal_max_d = raw;
				if (raw <= cal_min_q) begin
					cal_min_d = (raw != '0) ? raw - CAL_W'(1) : '0;
				end
				evt_d = EVT_MAX;
			end else if (press_q >= debounce_q) begin
				cal_min_d = raw;
				if (raw >= cal_max_q) begin
					cal_max_d = raw + CAL_W'(1);
				end
				evt_d = EVT_MIN;
			end
			press_d = '0;
		end
	end

	// configuration, calibration and press registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q <= RST_PERIOD_TOP;
			duty_min_q   <= RST_DUTY_MIN;
			duty_max_q   <= RST_DUTY_MAX;
			debounce_q   <= RST_DEBOUNCE;
			long_press_q <= RST_LONG_PRESS;
			init_min_q   <= '0;
			init_max_q   <= ADC_FULL;
			cal_min_q    <= '0;
			cal_max_q    <= ADC_FULL;
			press_q      <= '0;
			was_down_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_PERIOD_TOP: period_top_q <= cfg_data[TOP_W-1:0];
					REG_DUTY_MIN:   duty_min_q   <= cfg_data[PCT_W-1:0];
					REG_DUTY_MAX:   duty_max_q   <= cfg_data[PCT_W-1:0];
					REG_DEBOUNCE:   debounce_q   <= cfg_data[MS_W-1:0];
					REG_LONG_PRESS: long_press_q <= cfg_data[MS_W-1:0];
					REG_INIT_MIN: begin
						init_min_q <= cfg_data[CAL_W-1:0];
						cal_min_q  <= ld_min;
						cal_max_q  <= ld_max;
					end
					REG_INIT_MAX: begin
						init_max_q <= cfg_data[CAL_W-1:0];
						cal_min_q  <= ld_min;
						cal_max_q  <= ld_max;
					end
					default: begin
					end
				endcase
			end else if (cmd.accept) begin
				cal_min_q  <= cal_min_d;
				cal_max_q  <= cal_max_d;
				press_q    <= press_d;
				was_down_q <= button_down;
			end
		end
	end

	// stage one: offset reading and span from the old window
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			adj_s1   <= adc_c - cal_min_q;
			span1_s1 <= DIV_DEN_W'(cal_max_q) - DIV_DEN_W'(cal_min_q) + DIV_DEN_W'(1);
			pmin_s1  <= pmin_c;
			pmax_s1  <= pmax_c;
			evt_s1   <= evt_d;
			cmin_s1  <= cal_min_d;
			cmax_s1  <= cal_max_d;
		end
	end

	// stage two: products with the period
	logic [PER_W-1:0] top1;
	logic [27:0]      prod_c;
	logic [27:0]      plo_c;
	logic [27:0]      phi_c;

	assign top1   = {1'b0, period_top_q} + PER_W'(1);
	assign prod_c = {17'd0, adj_s1} * {11'd0, top1};
	assign plo_c  = {21'd0, pmin_s1} * {11'd0, top1};
	assign phi_c  = {21'd0, pmax_s1} * {11'd0, top1};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s2 <= prod_c[DIV_NUM_W-1:0];
			plo_s2  <= plo_c[PCT_NUM_W-1:0];
			phi_s2  <= phi_c[PCT_NUM_W-1:0];
		end
	end

	// serial divider for the scaled value
	a2pwm_div u_div_ccr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_s2),
		.den    (span1_s1),
		.quo    (q_ccr),
		.done   (d_ccr)
	);

	// percentage bounds: divide by one hundred through the reciprocal
	logic [PCT_PROD_W-1:0] lo_prod_c;
	logic [PCT_PROD_W-1:0] hi_prod_c;

	assign lo_prod_c = {PCT_RECIP_W'(0), plo_s2} * {PCT_NUM_W'(0), PCT_RECIP};
	assign hi_prod_c = {PCT_RECIP_W'(0), phi_s2} * {PCT_NUM_W'(0), PCT_RECIP};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			lo_div_s2 <= BND_W'(lo_prod_c[PCT_PROD_W-1:PCT_SHIFT]);
			hi_div_s2 <= BND_W'(hi_prod_c[PCT_PROD_W-1:PCT_SHIFT]);
		end
	end

	// stage three: bound fix-ups
	logic [BND_W-1:0] lo_c;
	logic [BND_W-1:0] hi_c;
	logic [BND_W-1:0] top_b;

	always_comb begin
		top_b = {2'b00, period_top_q};
		lo_c  = lo_div_s2;
		hi_c  = hi_div_s2;
		if (lo_c == '0) begin
			lo_c = BND_W'(1);
		end
		if (hi_c >= top_b) begin
			hi_c = (top_b != '0) ? top_b - BND_W'(1) : '0;
		end
		if (hi_c <= lo_c) begin
			hi_c = lo_c + BND_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fix) begin
			ccr_s3 <= q_ccr[BND_W-1:0];
			lo_s3  <= lo_c;
			hi_s3  <= hi_c;
		end
	end

	// final clamp with saturation
	logic [BND_W-1:0] clamp_c;
	logic [CMP_W-1:0] sat_c;

	always_comb begin
		clamp_c = ccr_s3;
		if (clamp_c < lo_s3) begin
			clamp_c = lo_s3;
		end
		if (clamp_c > hi_s3) begin
			clamp_c = hi_s3;
		end
		sat_c = (clamp_c[BND_W-1:CMP_W] != '0) ? '1 : clamp_c[CMP_W-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cmp_q  <= sat_c;
			evt_q  <= evt_s1;
			cmin_q <= cmin_s1;
			cmax_q <= cmax_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_value = cmp_q;
	assign save_event    = evt_q;
	assign cal_min_out   = cmin_q;
	assign cal_max_out   = cmax_q;

	assign sts.div_done = d_ccr;
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

### hw/rtl/adc_to_pwm_duty_with_button_calibration_core.sv
// ADC reading to PWM compare value, with push-button calibration.
// Input channel (in_valid/in_stall): one request per tick carrying the
// averaged reading and the button level. Output channel (out_valid/
// out_stall): one result per request with the compare value, the save
// event and the calibration window after the tick.
// Configuration: cfg_write with cfg_index and cfg_data writes one
// register; writing either initial calibration register reloads the
// window at once.
// The scaled value comes from the serial divider (27 steps, one quotient
// bit a cycle); both percentage bounds come from a reciprocal multiply
// meanwhile. The next request is taken while the previous result still
// sits in the output register.
// Press timing and calibration are updated at the accept edge unless
// cfg_write is high; the compare value uses the window before the update.
// Reset: configuration returns to its defaults, the window to 0..1023,
// press state clears and no result is pending.
// A stalled result holds; a finished request waits in the last step until
// the output register is free, and no new request is taken meanwhile.
module adc_to_pwm_duty_with_button_calibration_core
	import a2pwm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ADC_W-1:0]      adc_average,
	input  logic                  button_down,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CMP_W-1:0]      compare_value,
	output logic [EVT_W-1:0]      save_event,
	output logic [CAL_W-1:0]      cal_min_out,
	output logic [CAL_W-1:0]      cal_max_out
);

	a2pwm_cmd_t cmd;
	a2pwm_sts_t sts;

	// sequencer
	a2pwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, state and output register
	a2pwm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.adc_average   (adc_average),
		.button_down   (button_down),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.compare_value (compare_value),
		.save_event    (save_event),
		.cal_min_out   (cal_min_out),
		.cal_max_out   (cal_max_out),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule
